// ===== sv/btpc_pkg.sv =====
// btpc_pkg: constants shared by the pressure/temperature compensation unit
// and its checker. No dependencies.
`default_nettype none
package btpc_pkg;

  localparam int unsigned ARITH_WIDTH_DEF = 32;

  localparam int unsigned RAW_T_W  = 16;
  localparam int unsigned RAW_P_W  = 24;
  localparam int unsigned TEMP_W   = 28;
  localparam int unsigned PRESS_W  = 32;
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 64;
  localparam int unsigned CFG_W    = 64;

  // register indexes
  localparam logic [1:0] CFG_CAL_A = 2'd0;
  localparam logic [1:0] CFG_CAL_B = 2'd1;
  localparam logic [1:0] CFG_CAL_C = 2'd2;
  localparam logic [1:0] CFG_OSS   = 2'd3;

  localparam logic [1:0] OSS_RESET = 2'd1;

  localparam int unsigned C_B6_OFS   = 4000;
  localparam int unsigned C_X3_OFS   = 32768;
  localparam int unsigned C_B7_SCALE = 50000;
  localparam longint unsigned C_B7_LIM = 64'h8000_0000;
  localparam int unsigned C_P_K1     = 3038;
  localparam int          C_P_K2     = -7357;
  localparam int unsigned C_P_OFS    = 3791;

endpackage
`default_nettype wire

// ===== sv/baro_temp_pressure_compensation_unit.sv =====
// baro_temp_pressure_compensation_unit: pipelined integer compensation of
// raw temperature and pressure words. Depends on btpc_pkg.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: raw_temperature[15:0], raw_pressure[39:16]
//  m_axis   | out       | tdata: temperature_tenths[27:0], pressure_pa[59:28]
//           |           | tuser: divide_error
//  cfg      | in        | cfg_index_i register index, cfg_data_i value
//
// one request per cycle unless the output stalls; each request passes through the two
// restoring dividers, of one quotient bit per stage, before its result is offered.
// reset clears valid bits and loads the register defaults.
// a full output stalls the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module baro_temp_pressure_compensation_unit #(
  parameter int unsigned ARITH_WIDTH = btpc_pkg::ARITH_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [btpc_pkg::S_DATA_W-1:0]  s_axis_tdata,  // raw_temperature, raw_pressure
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output      logic [btpc_pkg::M_DATA_W-1:0]  m_axis_tdata,  // temperature_tenths, pressure_pa
  output      logic                           m_axis_tuser,  // divide_error
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [1:0]                     cfg_index_i,
  input  wire logic [btpc_pkg::CFG_W-1:0]     cfg_data_i
);
  import btpc_pkg::*;

  localparam int unsigned W  = ARITH_WIDTH;
  localparam int unsigned NS = 2 * W + 14;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] aq;
    logic [W-1:0] dvs;
  } div_t;

  typedef struct packed {
    div_t                dv;
    logic signed [W-1:0] x1;
    logic [RAW_P_W-1:0]  up;
    logic                neg;
    logic                dz;
  } d1_t;

  typedef struct packed {
    div_t               dv;
    logic [TEMP_W-1:0]  t;
    logic               dz;
    logic               b4z;
    logic               dbl;
  } d2_t;

  function automatic div_t dstep(input div_t s);
    logic [W:0] tr;
    div_t       o;
    tr = {s.rem, s.aq[W-1]};
    o  = s;
    if (tr >= {1'b0, s.dvs}) begin
      o.rem = W'(tr - {1'b0, s.dvs});
      o.aq  = {s.aq[W-2:0], 1'b1};
    end else begin
      o.rem = tr[W-1:0];
      o.aq  = {s.aq[W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    return x[W-1] ? W'(-x) : x;
  endfunction

  // configuration
  logic [63:0] cal_a_q, cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      oss_q   <= OSS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CAL_A: cal_a_q <= cfg_data_i;
        CFG_CAL_B: cal_b_q <= cfg_data_i;
        CFG_CAL_C: cal_c_q <= cfg_data_i[31:0];
        CFG_OSS:   oss_q   <= cfg_data_i[1:0];
        default:   ;
      endcase
    end
  end

  logic signed [W-1:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [W-1:0]        ac4, ac5, ac6;
  assign ac1 = W'($signed(cal_a_q[63:48]));
  assign ac2 = W'($signed(cal_a_q[47:32]));
  assign ac3 = W'($signed(cal_a_q[31:16]));
  assign ac4 = W'(cal_a_q[15:0]);
  assign ac5 = W'(cal_b_q[63:48]);
  assign ac6 = W'(cal_b_q[47:32]);
  assign b1  = W'($signed(cal_b_q[31:16]));
  assign b2  = W'($signed(cal_b_q[15:0]));
  assign mc  = W'($signed(cal_c_q[31:16]));
  assign md  = W'($signed(cal_c_q[15:0]));

  // valid chain and global advance
  logic [NS-1:0] vld_q;
  logic          en;

  assign en            = !vld_q[NS-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
    end
  end

  // stage registers
  logic [RAW_T_W-1:0]  ut_q;
  logic [RAW_P_W-1:0]  up_q, up1_q, up3_q, up4_q, up5_q, up6_q;
  logic signed [W-1:0] x1_q;
  d1_t                 d1_q [0:W];
  logic [TEMP_W-1:0]   t3_q, t4_q, t5_q, t6_q, t7_q, t9_q, t10_q, t11_q, t12_q;
  logic                dz3_q, dz4_q, dz5_q, dz6_q, dz7_q, dz9_q, dz10_q, dz11_q;
  logic signed [W-1:0] b6_q, sq_q, xa2_q, xc1_q, xa2b_q, xc1b_q, xa1_q, xc2_q;
  logic signed [W-1:0] b3_q, xx_q;
  logic [W-1:0]        b4_q, b7_q;
  d2_t                 d2_q [0:W];
  logic [W-1:0]        p9_q;
  logic signed [W-1:0] p10_q, p11_q, x1p_q, x2p_q, x1p2_q, x2p2_q;
  logic                b4z9_q, b4z10_q, b4z11_q;
  logic signed [W-1:0] p11b_q;
  logic [TEMP_W-1:0]   t11b_q;
  logic                dz11b_q, b4z11b_q;
  logic [PRESS_W-1:0]  p12_q;
  logic                err12_q;

  // combinational stage results
  logic signed [W-1:0] s1_dif, s1_prod, s2_d, s2_num;
  logic signed [W-1:0] s3_q, s3_b5;
  logic signed [W-1:0] s4_sq, s4_a2, s4_c1;
  logic signed [W-1:0] s5_a1, s5_c2;
  logic signed [W-1:0] s6_sum, s6_b3, s6_x3;
  logic [W-1:0]        s7_b4p, s7_b7, s7_scl;
  logic                s8_dbl;
  logic signed [W-1:0] s10_ps, s10_sq, s10_m2, s11_m1, s12_s, s12_c;
  logic signed [W-1:0] s9_p;

  always_comb begin
    s1_dif  = W'(W'(ut_q) - ac6);
    s1_prod = W'(s1_dif * $signed(ac5));
    s2_d    = W'(x1_q + md);
    s2_num  = W'(mc <<< 11);
    s3_q    = d1_q[W].neg ? W'(-$signed(d1_q[W].dv.aq)) : $signed(d1_q[W].dv.aq);
    s3_b5   = W'(d1_q[W].x1 + s3_q);
    s4_sq   = W'(b6_q * b6_q);
    s4_a2   = W'(ac2 * b6_q);
    s4_c1   = W'(ac3 * b6_q);
    s5_a1   = W'(b2 * sq_q);
    s5_c2   = W'(b1 * sq_q);
    s6_sum  = W'((ac1 <<< 2) + xa1_q + xa2b_q);
    s6_b3   = W'(W'(s6_sum <<< oss_q) + W'(2));
    s6_x3   = W'(xc1b_q + xc2_q + W'(2));
    s7_b4p  = W'(ac4 * $unsigned(xx_q));
    s7_scl  = W'(C_B7_SCALE) >> oss_q;
    s7_b7   = W'((W'(up6_q) - $unsigned(b3_q)) * s7_scl);
    s8_dbl  = b7_q >= W'(C_B7_LIM);
    s9_p    = d2_q[W].dbl ? $signed({d2_q[W].dv.aq[W-2:0], 1'b0}) : $signed(d2_q[W].dv.aq);
    s10_ps  = p10_q >>> 8;
    s10_sq  = W'(s10_ps * s10_ps);
    s10_m2  = W'(W'(C_P_K2) * p10_q);
    s11_m1  = W'(x1p_q * $signed(W'(C_P_K1)));
    s12_s   = W'(x1p2_q + x2p2_q + W'(C_P_OFS));
    s12_c   = W'(s12_s + (s12_s[W-1] ? W'(15) : W'(0))) >>> 4;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ut_q  <= s_axis_tdata[15:0];
      up_q  <= s_axis_tdata[39:16] >> (4'd8 - {2'b00, oss_q});
      x1_q  <= s1_prod >>> 15;
      up1_q <= up_q;

      d1_q[0].dv.rem <= '0;
      d1_q[0].dv.aq  <= mag(s2_num);
      d1_q[0].dv.dvs <= mag(s2_d);
      d1_q[0].x1     <= x1_q;
      d1_q[0].up     <= up1_q;
      d1_q[0].neg    <= s2_num[W-1] ^ s2_d[W-1];
      d1_q[0].dz     <= (s2_d == '0);
      for (int k = 0; k < W; k++) begin
        d1_q[k+1].dv  <= dstep(d1_q[k].dv);
        d1_q[k+1].x1  <= d1_q[k].x1;
        d1_q[k+1].up  <= d1_q[k].up;
        d1_q[k+1].neg <= d1_q[k].neg;
        d1_q[k+1].dz  <= d1_q[k].dz;
      end

      t3_q  <= TEMP_W'(W'(s3_b5 + W'(8)) >>> 4);
      b6_q  <= W'(s3_b5 - W'(C_B6_OFS));
      up3_q <= d1_q[W].up;
      dz3_q <= d1_q[W].dz;

      sq_q  <= s4_sq >>> 12;
      xa2_q <= s4_a2 >>> 11;
      xc1_q <= s4_c1 >>> 13;
      t4_q  <= t3_q;
      up4_q <= up3_q;
      dz4_q <= dz3_q;

      xa1_q  <= s5_a1 >>> 11;
      xc2_q  <= s5_c2 >>> 16;
      xa2b_q <= xa2_q;
      xc1b_q <= xc1_q;
      t5_q   <= t4_q;
      up5_q  <= up4_q;
      dz5_q  <= dz4_q;

      b3_q  <= s6_b3 >>> 2;
      xx_q  <= W'((s6_x3 >>> 2) + $signed(W'(C_X3_OFS)));
      t6_q  <= t5_q;
      up6_q <= up5_q;
      dz6_q <= dz5_q;

      b4_q  <= s7_b4p >> 15;
      b7_q  <= s7_b7;
      t7_q  <= t6_q;
      dz7_q <= dz6_q;

      d2_q[0].dv.rem <= '0;
      d2_q[0].dv.aq  <= s8_dbl ? b7_q : {b7_q[W-2:0], 1'b0};
      d2_q[0].dv.dvs <= b4_q;
      d2_q[0].t      <= t7_q;
      d2_q[0].dz     <= dz7_q;
      d2_q[0].b4z    <= (b4_q == '0);
      d2_q[0].dbl    <= s8_dbl;
      for (int k = 0; k < W; k++) begin
        d2_q[k+1].dv  <= dstep(d2_q[k].dv);
        d2_q[k+1].t   <= d2_q[k].t;
        d2_q[k+1].dz  <= d2_q[k].dz;
        d2_q[k+1].b4z <= d2_q[k].b4z;
        d2_q[k+1].dbl <= d2_q[k].dbl;
      end

      p9_q   <= s9_p;
      t9_q   <= d2_q[W].t;
      dz9_q  <= d2_q[W].dz;
      b4z9_q <= d2_q[W].b4z;

      p10_q   <= p9_q;
      t10_q   <= t9_q;
      dz10_q  <= dz9_q;
      b4z10_q <= b4z9_q;

      x1p_q   <= s10_sq;
      x2p_q   <= s10_m2 >>> 16;
      p11_q   <= p10_q;
      t11_q   <= t10_q;
      dz11_q  <= dz10_q;
      b4z11_q <= b4z10_q;

      x1p2_q   <= s11_m1 >>> 16;
      x2p2_q   <= x2p_q;
      p11b_q   <= p11_q;
      t11b_q   <= t11_q;
      dz11b_q  <= dz11_q;
      b4z11b_q <= b4z11_q;

      if (dz11b_q) begin
        t12_q   <= '0;
        p12_q   <= '0;
        err12_q <= 1'b1;
      end else if (b4z11b_q) begin
        t12_q   <= t11b_q;
        p12_q   <= '0;
        err12_q <= 1'b1;
      end else begin
        t12_q   <= t11b_q;
        p12_q   <= PRESS_W'(W'(p11b_q + s12_c));
        err12_q <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {4'b0000, p12_q, t12_q};
  assign m_axis_tuser = err12_q;

endmodule
`default_nettype wire

// ===== sv/btpc_chk.sv =====
// btpc_chk: port-level checks for the compensation unit, bound to its top.
// Depends on btpc_pkg.
`default_nettype none
module btpc_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [btpc_pkg::M_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser
);
  import btpc_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output request changed while stalled");

  a_err_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[59:28] == '0)
    else $error("pressure not zero on divide error");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input blocked with free output");

endmodule

bind baro_temp_pressure_compensation_unit btpc_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== bench/baro_temp_pressure_compensation_unit_test.sv =====
// testbench for baro_temp_pressure_compensation_unit: drives raw temperature and
// pressure requests, predicts compensated results and checks them in order.
// depends on btpc_pkg and the unit.
`default_nettype none
module baro_temp_pressure_compensation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  localparam int LATENCY = 2 * 32 + 14;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [27:0] temp;
    logic [31:0] press;
    logic        derr;
  } comp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0] oss_reg;
  comp_t comp_queue[$];
  int errors = 0;
  int n_checked = 0;
  int n_div_err = 0;
  longint cycles = 0;

  baro_temp_pressure_compensation_unit DUT (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("baro_temp_pressure_compensation_unit_test: done, errors");
      $finish;
    end
  end

  function automatic logic signed [31:0] sdiv32(logic signed [31:0] a, logic signed [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic comp_t compensate(logic [15:0] ut, logic [23:0] raw);
    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic signed [31:0] x1, x2, x3, d, b5, t, b6, sq, b3, p;
    logic [31:0] ac4, ac5, ac6, up, b4, b7, pu;
    comp_t r;
    ac1 = $signed(cal_a[63:48]); ac2 = $signed(cal_a[47:32]);
    ac3 = $signed(cal_a[31:16]); ac4 = cal_a[15:0];
    ac5 = cal_b[63:48]; ac6 = cal_b[47:32];
    b1 = $signed(cal_b[31:16]); b2 = $signed(cal_b[15:0]);
    mc = $signed(cal_c[31:16]); md = $signed(cal_c[15:0]);
    up = {8'd0, raw} >> (8 - oss_reg);
    x1 = ($signed({16'd0, ut}) - $signed(ac6)) * $signed(ac5);
    x1 = x1 >>> 15;
    d = x1 + md;
    r = '0;
    if (d == 0) begin
      r.derr = 1'b1;
      return r;
    end
    x2 = sdiv32(mc * 2048, d);
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = (((ac1 * 4 + x3) << oss_reg) + 2) >>> 2;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    b7 = (up - b3) * (32'd50000 >> oss_reg);
    r.temp = t[27:0];
    if (b4 == 0) begin
      r.derr = 1'b1;
      return r;
    end
    if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
    else pu = (b7 / b4) * 2;
    p = pu;
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-32'sd7357 * p) >>> 16;
    p = p + sdiv32(x1 + x2 + 3791, 16);
    r.press = p;
    return r;
  endfunction

  // result checker with random stalls
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if (comp_queue.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        comp_t e;
        e = comp_queue.pop_front();
        n_checked++;
        if (e.derr) n_div_err++;
        if (m_axis_tdata[27:0] !== e.temp) begin
          $display("%0t temp exp %h got %h", $time, e.temp, m_axis_tdata[27:0]);
          errors++;
        end
        if (m_axis_tdata[59:28] !== e.press) begin
          $display("%0t press exp %h got %h", $time, e.press, m_axis_tdata[59:28]);
          errors++;
        end
        if (m_axis_tuser !== e.derr) begin
          $display("%0t derr exp %b got %b", $time, e.derr, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  task automatic send_reading(logic [15:0] ut, logic [23:0] raw);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {raw, ut};
    comp_queue.push_back(compensate(ut, raw));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (comp_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CAL_A: cal_a = val;
      CFG_CAL_B: cal_b = val;
      CFG_CAL_C: cal_c = val[31:0];
      default: oss_reg = val[1:0];
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic load_cal(logic [63:0] a, logic [63:0] b, logic [31:0] c, logic [1:0] o);
    drain();
    write_reg(CFG_CAL_A, a);
    write_reg(CFG_CAL_B, b);
    write_reg(CFG_CAL_C, {32'd0, c});
    write_reg(CFG_OSS, {62'd0, o});
  endtask

  task automatic test_reset_defaults;
    send_reading(16'd0, 24'd0);
    send_reading(16'hffff, 24'hffffff);
  endtask

  task automatic test_datasheet_example;
    load_cal({16'd408, -16'sd72, -16'sd14383, 16'd32741},
             {16'd32757, 16'd23153, 16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
    send_reading(16'd27898, 24'd23843 << 8);
    send_reading(16'd0, 24'd0);
    send_reading(16'hffff, 24'hffffff);
    for (int o = 1; o < 4; o++) begin
      drain();
      write_reg(CFG_OSS, {62'd0, 2'(o)});
      send_reading(16'd27898, 24'hffffff);
      send_reading(16'h8000, 24'h800000);
    end
  endtask

  task automatic test_divide_errors;
    // temperature divisor zero: ac5 zero gives x1 zero, md zero
    load_cal(64'h0123_4567_89ab_cdef, 64'h0000_1234_5678_9abc, 32'h1234_0000, 2'd2);
    send_reading(16'd1000, 24'h123456);
    send_reading(16'hffff, 24'd0);
    // pressure divisor zero: ac4 zero
    load_cal({16'd408, -16'sd72, -16'sd14383, 16'd0},
             {16'd32757, 16'd23153, 16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd3);
    send_reading(16'd27898, 24'h5d2300);
    send_reading(16'd0, 24'hffffff);
  endtask

  task automatic test_extreme_cal;
    load_cal(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 2'd3);
    send_reading(16'd0, 24'd0);
    send_reading(16'hffff, 24'hffffff);
    send_reading(16'h7fff, 24'h7fffff);
    load_cal(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 32'h8000_8000, 2'd0);
    send_reading(16'd1, 24'd1);
    send_reading(16'hffff, 24'hffffff);
  endtask

  task automatic test_random_cal;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase % 2 == 0)
        load_cal({16'($urandom_range(0, 2000)), 16'($urandom), 16'($urandom),
                  16'($urandom_range(20000, 40000))},
                 {16'($urandom_range(20000, 40000)), 16'($urandom), 16'($urandom),
                  16'($urandom)}, $urandom, 2'(phase % 4));
      else
        load_cal(rand64(), rand64(), $urandom, 2'($urandom_range(0, 3)));
      for (int i = 0; i < 100; i++) send_reading(16'($urandom), 24'($urandom));
      if (phase == 4) drain();
    end
  endtask

  initial begin
    cal_a = '0; cal_b = '0; cal_c = '0; oss_reg = OSS_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_datasheet_example();
    test_divide_errors();
    test_extreme_cal();
    test_random_cal();
    drain();
    $display("checked %0d results, %0d with divide errors, over reset, datasheet,",
             n_checked, n_div_err);
    $display("extreme and random calibration at all oversampling settings");
    if (errors == 0)
      $display("baro_temp_pressure_compensation_unit_test: done, clean");
    else
      $display("baro_temp_pressure_compensation_unit_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
